### rtl/core/circular_deque_top_assert.svh
// Assertion macros for the checker file of the deque.
// Both sample on the rising edge of clk_i and stay quiet while rst_ni is low.
`ifndef CIRCULAR_DEQUE_TOP_ASSERT_SVH
`define CIRCULAR_DEQUE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/cdq_pkg.sv
package cdq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef logic signed [31:0] word_t;

  typedef enum logic [2:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_REAR  = 3'd1,
    KIND_DEL_FRONT = 3'd2,
    KIND_DEL_REAR  = 3'd3,
    KIND_QUERY     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MODE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_FREE     = 2'd0,
    MODE_IN_RESTR = 2'd1,
    MODE_OUT_RESTR = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    CELL_HOLD       = 3'd0,
    CELL_PUSH_FRONT = 3'd1,
    CELL_POP_FRONT  = 3'd2,
    CELL_PUSH_REAR  = 3'd3,
    CELL_POP_REAR   = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    word_t    value;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0] kind;
    word_t      value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]       status;
    word_t            removed_value;
    word_t            front_value;
    word_t            rear_value;
    logic [CNT_W-1:0] occupancy;
    logic             is_full;
    logic             is_empty;
  } out_rsp_t;

endpackage

### rtl/core/circular_deque_top.sv
// A result is valid in the cycle after its request is accepted.
// One request per cycle while the input is not stalled; all cells of the row shift or write together.
// Requests stall only while a finished result waits and the output is stalled.
// Reset clears the cell valid bits, the count, the mode and the output valid;
// cell data is not reset.
module circular_deque_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cdq_pkg::in_req_t in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cdq_pkg::out_rsp_t out_rsp_o
);

  localparam int unsigned D = cdq_pkg::DEPTH;
  localparam int unsigned W = cdq_pkg::CNT_W;

  logic [1:0]          mode_q;
  logic [W-1:0]        cnt_d, cnt_q;
  logic                out_valid_q;
  cdq_pkg::out_rsp_t   rsp_d, rsp_q;
  cdq_pkg::cell_ctrl_t ctrl;

  logic                cell_valid [D];
  cdq_pkg::word_t      cell_data  [D];
  logic                cell_last  [D];

  logic                accept, allowed, is_ins, is_del, done;
  logic                empty_b, full_b, one_b;
  logic [2:0]          kind;
  cdq_pkg::status_e    status;
  cdq_pkg::word_t      front_b, rear_b, prelast_b;

  genvar gi;
  generate
    for (gi = 0; gi < D; gi++) begin : g_cell
      logic           lv, rv;
      cdq_pkg::word_t ld, rd;
      if (gi == 0) begin : g_first
        assign lv = 1'b1;
        assign ld = in_req_i.value;
      end else begin : g_mid
        assign lv = cell_valid[gi-1];
        assign ld = cell_data[gi-1];
      end
      if (gi == D - 1) begin : g_end
        assign rv = 1'b0;
        assign rd = '0;
      end else begin : g_nxt
        assign rv = cell_valid[gi+1];
        assign rd = cell_data[gi+1];
      end
      cdq_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl),
        .left_valid_i (lv),
        .left_data_i  (ld),
        .right_valid_i(rv),
        .right_data_i (rd),
        .valid_o      (cell_valid[gi]),
        .data_o       (cell_data[gi]),
        .last_o       (cell_last[gi])
      );
    end
  endgenerate

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign kind       = in_req_i.kind;

  assign empty_b = (cnt_q == '0);
  assign full_b  = (cnt_q == W'(D));
  assign one_b   = (cnt_q == W'(1));

  // The rear word and the one in front of it are found through the last-cell flags.
  always_comb begin
    rear_b    = '0;
    prelast_b = '0;
    for (int i = 0; i < D; i++) begin
      rear_b = rear_b | (cell_last[i] ? cell_data[i] : '0);
      if (i < D - 1) begin
        prelast_b = prelast_b | (cell_last[i+1] ? cell_data[i] : '0);
      end
    end
    front_b = empty_b ? '0 : cell_data[0];
  end

  always_comb begin
    is_ins  = (kind == cdq_pkg::KIND_INS_FRONT) || (kind == cdq_pkg::KIND_INS_REAR);
    is_del  = (kind == cdq_pkg::KIND_DEL_FRONT) || (kind == cdq_pkg::KIND_DEL_REAR);
    allowed = (kind <= cdq_pkg::KIND_QUERY)
           && !((mode_q == cdq_pkg::MODE_IN_RESTR) && (kind == cdq_pkg::KIND_INS_REAR))
           && !((mode_q == cdq_pkg::MODE_OUT_RESTR) && (kind == cdq_pkg::KIND_DEL_FRONT));
    priority if (!allowed) begin
      status = cdq_pkg::ST_MODE;
    end else if (is_ins && full_b) begin
      status = cdq_pkg::ST_FULL;
    end else if (is_del && empty_b) begin
      status = cdq_pkg::ST_EMPTY;
    end else begin
      status = cdq_pkg::ST_DONE;
    end
    done = (status == cdq_pkg::ST_DONE);
  end

  always_comb begin
    ctrl.value = in_req_i.value;
    ctrl.op    = cdq_pkg::CELL_HOLD;
    cnt_d      = cnt_q;
    rsp_d.status        = status;
    rsp_d.removed_value = '0;
    rsp_d.front_value   = front_b;
    rsp_d.rear_value    = rear_b;
    if (done) begin
      unique case (kind)
        cdq_pkg::KIND_INS_FRONT: begin
          ctrl.op = cdq_pkg::CELL_PUSH_FRONT;
          cnt_d   = cnt_q + W'(1);
          rsp_d.front_value = in_req_i.value;
          rsp_d.rear_value  = empty_b ? in_req_i.value : rear_b;
        end
        cdq_pkg::KIND_INS_REAR: begin
          ctrl.op = cdq_pkg::CELL_PUSH_REAR;
          cnt_d   = cnt_q + W'(1);
          rsp_d.front_value = empty_b ? in_req_i.value : front_b;
          rsp_d.rear_value  = in_req_i.value;
        end
        cdq_pkg::KIND_DEL_FRONT: begin
          ctrl.op = cdq_pkg::CELL_POP_FRONT;
          cnt_d   = cnt_q - W'(1);
          rsp_d.removed_value = cell_data[0];
          rsp_d.front_value   = one_b ? '0 : cell_data[1];
          rsp_d.rear_value    = one_b ? '0 : rear_b;
        end
        cdq_pkg::KIND_DEL_REAR: begin
          ctrl.op = cdq_pkg::CELL_POP_REAR;
          cnt_d   = cnt_q - W'(1);
          rsp_d.removed_value = rear_b;
          rsp_d.front_value   = one_b ? '0 : front_b;
          rsp_d.rear_value    = one_b ? '0 : prelast_b;
        end
        default: begin
        end
      endcase
    end
    if (!accept) begin
      ctrl.op = cdq_pkg::CELL_HOLD;
      cnt_d   = cnt_q;
    end
    rsp_d.occupancy = cnt_d;
    rsp_d.is_full   = (cnt_d == W'(D));
    rsp_d.is_empty  = (cnt_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= cdq_pkg::MODE_FREE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      cnt_q <= cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

### rtl/core/cdq_cell.sv
module cdq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cdq_pkg::cell_ctrl_t ctrl_i,
  input  logic               left_valid_i,
  input  cdq_pkg::word_t     left_data_i,
  input  logic               right_valid_i,
  input  cdq_pkg::word_t     right_data_i,
  output logic               valid_o,
  output cdq_pkg::word_t     data_o,
  output logic               last_o
);

  logic           valid_d, valid_q;
  cdq_pkg::word_t data_d, data_q;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    unique case (ctrl_i.op)
      cdq_pkg::CELL_HOLD: begin
      end
      cdq_pkg::CELL_PUSH_FRONT: begin
        valid_d = left_valid_i;
        data_d  = left_data_i;
      end
      cdq_pkg::CELL_POP_FRONT: begin
        valid_d = right_valid_i;
        data_d  = right_data_i;
      end
      cdq_pkg::CELL_PUSH_REAR: begin
        // Only the first empty cell behind the occupied run takes the word.
        if (!valid_q && left_valid_i) begin
          valid_d = 1'b1;
          data_d  = ctrl_i.value;
        end
      end
      cdq_pkg::CELL_POP_REAR: begin
        if (valid_q && !right_valid_i) begin
          valid_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign last_o  = valid_q && !right_valid_i;

endmodule

### rtl/core/cdq_checker.sv
`include "circular_deque_top_assert.svh"

module cdq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input cdq_pkg::out_rsp_t out_rsp_o
);

  logic in_fire, out_wait;
  logic empty_rsp, empty_clean;
  logic reject_rsp, removed_clean;
  logic single_rsp, ends_match;

  assign in_fire       = in_valid_i && !in_stall_o;
  assign out_wait      = out_valid_o && out_stall_i;
  assign empty_rsp     = out_valid_o && out_rsp_o.is_empty;
  assign empty_clean   = (out_rsp_o.front_value == '0) && (out_rsp_o.rear_value == '0)
                      && (out_rsp_o.occupancy == '0);
  assign reject_rsp    = out_valid_o && (out_rsp_o.status != cdq_pkg::ST_DONE);
  assign removed_clean = (out_rsp_o.removed_value == '0);
  assign single_rsp    = out_valid_o && (out_rsp_o.occupancy == cdq_pkg::CNT_W'(1));
  assign ends_match    = (out_rsp_o.front_value == out_rsp_o.rear_value);

  // A result that is not taken stays offered.
  `CDQ_ASSERT_NEXT(a_out_hold, out_wait, out_valid_o, "result dropped while stalled")

  // Every accepted request produces a result in the next cycle.
  `CDQ_ASSERT_NEXT(a_rsp_follows, in_fire, out_valid_o, "no result after request")

  // An empty deque reports no words and a zero count.
  `CDQ_ASSERT_NOW(a_empty_zero, empty_rsp, empty_clean, "empty result carries data")

  // Only a completed request may report a removed word.
  `CDQ_ASSERT_NOW(a_removed_zero, reject_rsp, removed_clean, "rejected request removed a word")

  // With one word held, front and rear are the same word.
  `CDQ_ASSERT_NOW(a_single_word, single_rsp, ends_match, "front and rear differ with one word")

endmodule

bind circular_deque_top cdq_checker u_cdq_checker (.*);

### tb/sv/tb_circular_deque_top.sv
module tb_circular_deque_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              IDX_W          = $clog2(cdq_pkg::DEPTH);
  localparam logic [1:0]      MODE_SPARE     = 2'd3;
  localparam cdq_pkg::word_t  WORD_MIN       = 32'sh8000_0000;
  localparam cdq_pkg::word_t  WORD_MAX       = 32'sh7fff_ffff;
  localparam int              WATCHDOG_LIMIT = 2000;
  localparam int              PRINT_LIMIT    = 100;

  localparam int STALL_NONE     = 0;
  localparam int STALL_RANDOM   = 1;
  localparam int STALL_PERIODIC = 2;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [1:0]        cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  cdq_pkg::in_req_t  in_req_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  cdq_pkg::out_rsp_t out_rsp_o;

  // Predicted deque contents and configuration.
  cdq_pkg::word_t     ring [cdq_pkg::DEPTH];
  logic [IDX_W-1:0]   front_idx;
  logic [IDX_W-1:0]   rear_idx;
  int unsigned        held;
  logic [1:0]         dq_mode;

  cdq_pkg::out_rsp_t expected_rsp[$];

  int error_count   = 0;
  int results_seen  = 0;
  int burst_left    = 0;
  bit gaps_on       = 1'b0;
  int stall_style   = STALL_NONE;
  int hold_request  = 0;

  circular_deque_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [IDX_W-1:0] idx_next(logic [IDX_W-1:0] i);
    return (i == IDX_W'(cdq_pkg::DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(cdq_pkg::DEPTH - 1) : i - 1'b1;
  endfunction

  function automatic cdq_pkg::out_rsp_t apply_request(cdq_pkg::in_req_t req);
    cdq_pkg::out_rsp_t rsp;
    logic              allowed;
    rsp = '0;
    allowed = (req.kind <= cdq_pkg::KIND_QUERY);
    if (dq_mode == cdq_pkg::MODE_IN_RESTR && req.kind == cdq_pkg::KIND_INS_REAR) allowed = 1'b0;
    if (dq_mode == cdq_pkg::MODE_OUT_RESTR && req.kind == cdq_pkg::KIND_DEL_FRONT) allowed = 1'b0;
    rsp.status = cdq_pkg::ST_DONE;
    // The mode check wins over the full and empty checks.
    if (!allowed) begin
      rsp.status = cdq_pkg::ST_MODE;
    end else if (req.kind == cdq_pkg::KIND_INS_FRONT || req.kind == cdq_pkg::KIND_INS_REAR) begin
      if (held == cdq_pkg::DEPTH) begin
        rsp.status = cdq_pkg::ST_FULL;
      end else begin
        if (held == 0) begin
          front_idx = '0;
          rear_idx  = '0;
          ring[0]   = req.value;
        end else if (req.kind == cdq_pkg::KIND_INS_FRONT) begin
          front_idx       = idx_prev(front_idx);
          ring[front_idx] = req.value;
        end else begin
          rear_idx       = idx_next(rear_idx);
          ring[rear_idx] = req.value;
        end
        held++;
      end
    end else if (req.kind == cdq_pkg::KIND_DEL_FRONT || req.kind == cdq_pkg::KIND_DEL_REAR) begin
      if (held == 0) begin
        rsp.status = cdq_pkg::ST_EMPTY;
      end else begin
        rsp.removed_value = (req.kind == cdq_pkg::KIND_DEL_FRONT) ? ring[front_idx]
                                                                  : ring[rear_idx];
        if (held == 1) begin
          front_idx = '0;
          rear_idx  = '0;
        end else if (req.kind == cdq_pkg::KIND_DEL_FRONT) begin
          front_idx = idx_next(front_idx);
        end else begin
          rear_idx = idx_prev(rear_idx);
        end
        held--;
      end
    end
    if (held != 0) begin
      rsp.front_value = ring[front_idx];
      rsp.rear_value  = ring[rear_idx];
    end
    rsp.occupancy = cdq_pkg::CNT_W'(held);
    rsp.is_full   = (held == cdq_pkg::DEPTH);
    rsp.is_empty  = (held == 0);
    return rsp;
  endfunction

  function automatic cdq_pkg::word_t pick_word();
    case ($urandom_range(0, 11))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return -1;
      default: return $urandom();
    endcase
  endfunction

  // Mostly kinds the current mode allows, so that runs really fill and drain.
  function automatic logic [2:0] pick_insert_kind();
    if (dq_mode == cdq_pkg::MODE_IN_RESTR && $urandom_range(0, 7) != 0) begin
      return cdq_pkg::KIND_INS_FRONT;
    end
    return $urandom_range(0, 1) ? cdq_pkg::KIND_INS_REAR : cdq_pkg::KIND_INS_FRONT;
  endfunction

  function automatic logic [2:0] pick_delete_kind();
    if (dq_mode == cdq_pkg::MODE_OUT_RESTR && $urandom_range(0, 7) != 0) begin
      return cdq_pkg::KIND_DEL_REAR;
    end
    return $urandom_range(0, 1) ? cdq_pkg::KIND_DEL_REAR : cdq_pkg::KIND_DEL_FRONT;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, field, got, want));
    end
  endtask

  task automatic send_request(input logic [2:0] kind, input cdq_pkg::word_t value);
    cdq_pkg::in_req_t req;
    int               gap;
    req.kind  = kind;
    req.value = value;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap        = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_rsp.push_back(apply_request(req));
    if (burst_left > 0) burst_left--;
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic [1:0] mode);
    wait_quiet();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dq_mode = mode;
  endtask

  task automatic run_random(input int count);
    int sent;
    int len;
    int seq;
    sent = 0;
    while (sent < count) begin
      seq = $urandom_range(0, 9);
      len = (seq < 7) ? $urandom_range(1, cdq_pkg::DEPTH + 3) : $urandom_range(1, 8);
      for (int i = 0; i < len && sent < count; i++) begin
        if (seq < 4) begin
          send_request(pick_insert_kind(), pick_word());
        end else if (seq < 7) begin
          send_request(pick_delete_kind(), pick_word());
        end else if ($urandom_range(0, 9) == 0) begin
          send_request(3'($urandom_range(int'(cdq_pkg::KIND_QUERY) + 1, 7)), pick_word());
        end else begin
          send_request(3'($urandom_range(0, int'(cdq_pkg::KIND_QUERY))), pick_word());
        end
        sent++;
      end
    end
  endtask

  // Empty rejects, undefined kinds, extreme words and emptying from both ends.
  task automatic test_empty_and_basic();
    gaps_on     = 1'b0;
    stall_style = STALL_NONE;
    send_request(cdq_pkg::KIND_DEL_FRONT, WORD_MAX);
    send_request(cdq_pkg::KIND_DEL_REAR, WORD_MIN);
    send_request(cdq_pkg::KIND_QUERY, -1);
    for (int k = int'(cdq_pkg::KIND_QUERY) + 1; k < 8; k++) send_request(3'(k), '0);
    send_request(cdq_pkg::KIND_INS_FRONT, WORD_MIN);
    send_request(cdq_pkg::KIND_INS_REAR, WORD_MAX);
    send_request(cdq_pkg::KIND_INS_FRONT, '0);
    send_request(cdq_pkg::KIND_INS_REAR, -1);
    send_request(cdq_pkg::KIND_QUERY, '0);
    send_request(cdq_pkg::KIND_DEL_FRONT, '0);
    send_request(cdq_pkg::KIND_DEL_REAR, '0);
    send_request(cdq_pkg::KIND_DEL_REAR, '0);
    send_request(cdq_pkg::KIND_DEL_FRONT, '0);
  endtask

  task automatic test_mode_rules();
    set_mode(cdq_pkg::MODE_IN_RESTR);
    send_request(cdq_pkg::KIND_INS_REAR, 32'sh1234_5678);
    send_request(cdq_pkg::KIND_INS_FRONT, 32'sh0bad_cafe);
    send_request(cdq_pkg::KIND_DEL_FRONT, '0);
    set_mode(cdq_pkg::MODE_OUT_RESTR);
    send_request(cdq_pkg::KIND_DEL_FRONT, '0);
    send_request(cdq_pkg::KIND_INS_REAR, 32'sh5a5a_a5a5);
    send_request(cdq_pkg::KIND_DEL_REAR, '0);
    set_mode(MODE_SPARE);
    send_request(cdq_pkg::KIND_INS_REAR, -2);
    send_request(cdq_pkg::KIND_DEL_FRONT, '0);
  endtask

  task automatic test_random_free();
    set_mode(cdq_pkg::MODE_FREE);
    gaps_on     = 1'b0;
    stall_style = STALL_NONE;
    run_random(50);
    gaps_on     = 1'b1;
    stall_style = STALL_RANDOM;
    run_random(70);
    stall_style = STALL_PERIODIC;
    run_random(50);
  endtask

  task automatic test_random_modes();
    gaps_on     = 1'b1;
    stall_style = STALL_RANDOM;
    set_mode(cdq_pkg::MODE_IN_RESTR);
    run_random(70);
    set_mode(cdq_pkg::MODE_OUT_RESTR);
    stall_style = STALL_PERIODIC;
    run_random(70);
    set_mode(MODE_SPARE);
    stall_style = STALL_RANDOM;
    run_random(50);
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_back_pressure();
    set_mode(cdq_pkg::MODE_FREE);
    gaps_on      = 1'b0;
    stall_style  = STALL_NONE;
    hold_request = 60;
    run_random(60);
  endtask

  always @(posedge clk_i) begin : receiver_stall
    int hold_left;
    int phase;
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      case (stall_style)
        STALL_RANDOM: out_stall_i <= ($urandom_range(0, 2) == 0);
        STALL_PERIODIC: begin
          phase = (phase + 1) % 7;
          out_stall_i <= (phase < 3);
        end
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  always @(posedge clk_i) begin : result_check
    cdq_pkg::out_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no request pending",
                                  results_seen));
      end else begin
        want = expected_rsp.pop_front();
        check_field("status", 32'(out_rsp_o.status), 32'(want.status));
        check_field("removed_value", out_rsp_o.removed_value, want.removed_value);
        check_field("front_value", out_rsp_o.front_value, want.front_value);
        check_field("rear_value", out_rsp_o.rear_value, want.rear_value);
        check_field("occupancy", 32'(out_rsp_o.occupancy), 32'(want.occupancy));
        check_field("is_full", 32'(out_rsp_o.is_full), 32'(want.is_full));
        check_field("is_empty", 32'(out_rsp_o.is_empty), 32'(want.is_empty));
      end
      results_seen++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    held      = 0;
    front_idx = '0;
    rear_idx  = '0;
    dq_mode   = cdq_pkg::MODE_FREE;
    foreach (ring[i]) ring[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_basic();
    test_mode_rules();
    test_random_free();
    test_random_modes();
    test_back_pressure();

    wait_quiet();
    repeat (4) @(posedge clk_i);
    if (expected_rsp.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", expected_rsp.size()));
    end
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
